// ===== src/quadric_taubin_distance_max_macros.svh =====
// Assertion macros for the quadric Taubin distance block
`ifndef QUADRIC_TAUBIN_DISTANCE_MAX_MACROS_SVH
`define QUADRIC_TAUBIN_DISTANCE_MAX_MACROS_SVH
`ifndef SYNTHESIS
`define QTD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("qtd assertion failed");
`define QTD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("qtd assertion failed");
`else
`define QTD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define QTD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== src/qtd_pkg.sv =====
// Types, constants and the multiply schedule of the quadric Taubin distance block
package qtd_pkg;

    localparam int COORD_W   = 16;
    localparam int COEF_W    = 32;
    localparam int PROD_W    = 64;
    localparam int ACC_W     = 64;
    localparam int MAG_W     = 40;
    localparam int T_W       = 31;
    localparam int FM_W      = 48;
    localparam int ROOT_W    = 32;
    localparam int DIST_W    = 24;
    localparam int DIV_W     = 48;
    localparam int STEP_W    = 5;
    localparam int SHIFT_W   = 4;
    localparam int NUM_COEF  = 10;
    localparam int NUM_PAIR  = 5;
    localparam int NUM_MONO  = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;

    localparam logic [DIST_W-1:0] DIST_FULL = '1;

    localparam logic [STEP_W-1:0] STEP_LAST_G = 5'd23;
    localparam logic [STEP_W-1:0] STEP_LAST   = 5'd26;

    localparam logic [CFG_IDX_W-1:0] REG_PAIR_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_E = 3'd4;

    typedef enum logic [1:0] {SRC_COORD, SRC_COEF, SRC_MONO, SRC_T} src_t;
    typedef enum logic [2:0] {DST_MONO, DST_F12, DST_F24, DST_G, DST_SUM} dst_t;

    typedef struct packed {
        src_t       a_sel;
        logic [3:0] a_idx;
        src_t       b_sel;
        logic [3:0] b_idx;
        dst_t       dst;
        logic [2:0] d_idx;
        logic       dbl;
    } step_t;

    function automatic step_t mk(input src_t as, input int ai, input src_t bs, input int bi,
                                 input dst_t d, input int di, input logic db);
        step_t r;
        r.a_sel = as;
        r.a_idx = 4'(ai);
        r.b_sel = bs;
        r.b_idx = 4'(bi);
        r.dst   = d;
        r.d_idx = 3'(di);
        r.dbl   = db;
        return r;
    endfunction

    // one multiply per step: monomials, terms of f, gradient terms, squares
    function automatic step_t step_op(input logic [STEP_W-1:0] step);
        step_t r;
        case (step)
            5'd0:  r = mk(SRC_COORD, 0, SRC_COORD, 0, DST_MONO, 0, 1'b0);
            5'd1:  r = mk(SRC_COORD, 0, SRC_COORD, 1, DST_MONO, 1, 1'b0);
            5'd2:  r = mk(SRC_COORD, 0, SRC_COORD, 2, DST_MONO, 2, 1'b0);
            5'd3:  r = mk(SRC_COORD, 1, SRC_COORD, 1, DST_MONO, 3, 1'b0);
            5'd4:  r = mk(SRC_COORD, 1, SRC_COORD, 2, DST_MONO, 4, 1'b0);
            5'd5:  r = mk(SRC_COORD, 2, SRC_COORD, 2, DST_MONO, 5, 1'b0);
            5'd6:  r = mk(SRC_COEF, 1, SRC_COORD, 0, DST_F12, 0, 1'b0);
            5'd7:  r = mk(SRC_COEF, 2, SRC_COORD, 1, DST_F12, 0, 1'b0);
            5'd8:  r = mk(SRC_COEF, 3, SRC_COORD, 2, DST_F12, 0, 1'b0);
            5'd9:  r = mk(SRC_COEF, 4, SRC_MONO, 0, DST_F24, 0, 1'b0);
            5'd10: r = mk(SRC_COEF, 5, SRC_MONO, 1, DST_F24, 0, 1'b0);
            5'd11: r = mk(SRC_COEF, 6, SRC_MONO, 2, DST_F24, 0, 1'b0);
            5'd12: r = mk(SRC_COEF, 7, SRC_MONO, 3, DST_F24, 0, 1'b0);
            5'd13: r = mk(SRC_COEF, 8, SRC_MONO, 4, DST_F24, 0, 1'b0);
            5'd14: r = mk(SRC_COEF, 9, SRC_MONO, 5, DST_F24, 0, 1'b0);
            5'd15: r = mk(SRC_COEF, 4, SRC_COORD, 0, DST_G, 0, 1'b1);
            5'd16: r = mk(SRC_COEF, 5, SRC_COORD, 1, DST_G, 0, 1'b0);
            5'd17: r = mk(SRC_COEF, 6, SRC_COORD, 2, DST_G, 0, 1'b0);
            5'd18: r = mk(SRC_COEF, 5, SRC_COORD, 0, DST_G, 1, 1'b0);
            5'd19: r = mk(SRC_COEF, 7, SRC_COORD, 1, DST_G, 1, 1'b1);
            5'd20: r = mk(SRC_COEF, 8, SRC_COORD, 2, DST_G, 1, 1'b0);
            5'd21: r = mk(SRC_COEF, 6, SRC_COORD, 0, DST_G, 2, 1'b0);
            5'd22: r = mk(SRC_COEF, 8, SRC_COORD, 1, DST_G, 2, 1'b0);
            5'd23: r = mk(SRC_COEF, 9, SRC_COORD, 2, DST_G, 2, 1'b1);
            5'd24: r = mk(SRC_T, 0, SRC_T, 0, DST_SUM, 0, 1'b0);
            5'd25: r = mk(SRC_T, 1, SRC_T, 1, DST_SUM, 0, 1'b0);
            5'd26: r = mk(SRC_T, 2, SRC_T, 2, DST_SUM, 0, 1'b0);
            default: r = mk(SRC_T, 0, SRC_T, 0, DST_SUM, 0, 1'b0);
        endcase
        return r;
    endfunction

endpackage

// ===== src/qtd_mul.sv =====
// Bit-serial signed multiplier, one multiplier bit per cycle
module qtd_mul import qtd_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [COEF_W-1:0] op_a,
    input  logic signed [COEF_W-1:0] op_b,
    output logic                     busy,
    output logic                     done,
    output logic signed [PROD_W-1:0] prod
);

    localparam int CNT_W = $clog2(COEF_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(COEF_W - 1);

    logic                     run_reg, fix_reg, done_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [COEF_W-1:0]        hi_reg, lo_reg, mcand_reg;
    logic                     neg_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [COEF_W:0]          sum;
    logic [COEF_W-1:0]        mag_a, mag_b;

    always_comb begin
        mag_a = op_a[COEF_W-1] ? COEF_W'(-op_a) : COEF_W'(op_a);
        mag_b = op_b[COEF_W-1] ? COEF_W'(-op_b) : COEF_W'(op_b);
        sum   = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= fix_reg;
            fix_reg  <= run_reg && (cnt_reg == CNT_LAST);
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mcand_reg <= mag_a;
            lo_reg    <= mag_b;
            hi_reg    <= '0;
            neg_reg   <= op_a[COEF_W-1] ^ op_b[COEF_W-1];
        end else if (run_reg) begin
            hi_reg <= sum[COEF_W:1];
            lo_reg <= {sum[0], lo_reg[COEF_W-1:1]};
        end
        if (fix_reg) begin
            prod_reg <= neg_reg ? -$signed({hi_reg, lo_reg}) : $signed({hi_reg, lo_reg});
        end
    end

    assign busy = run_reg | fix_reg;
    assign done = done_reg;
    assign prod = prod_reg;

endmodule

// ===== src/qtd_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle
module qtd_sqrt import qtd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [ACC_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int CNT_W = $clog2(ROOT_W);
    localparam int REM_W = ROOT_W + 4;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROOT_W - 1);

    logic              run_reg, done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [ACC_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W-1:0]  rem_sh, trial;
    logic              ge;

    always_comb begin
        rem_sh = {rem_reg[REM_W-3:0], rad_reg[ACC_W-1 -: 2]};
        trial  = {2'b00, root_reg, 2'b01};
        ge     = rem_sh >= trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= run_reg && (cnt_reg == CNT_LAST);
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (run_reg) begin
            rad_reg  <= {rad_reg[ACC_W-3:0], 2'b00};
            rem_reg  <= ge ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== src/qtd_div.sv =====
// Restoring divider, one quotient bit per cycle, with overflow check up front
module qtd_div import qtd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [ACC_W-1:0]  dividend,
    input  logic [DIV_W-1:0]  divisor,
    output logic              done,
    output logic              ovf,
    output logic [DIST_W-1:0] quot
);

    localparam int CNT_W = $clog2(DIST_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIST_W - 1);

    logic              run_reg, done_reg, ovf_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIV_W-1:0]  rem_reg, div_reg;
    logic [DIST_W-1:0] low_reg, q_reg;
    logic              ovf_c, ge;
    logic [DIV_W:0]    cand;
    logic [DIV_W+1:0]  diff;

    always_comb begin
        // quotient fits 24 bits only if the upper dividend part is below the divisor
        ovf_c = DIV_W'(dividend[ACC_W-1:DIST_W]) >= divisor;
        cand  = {rem_reg, low_reg[DIST_W-1]};
        diff  = {1'b0, cand} - {2'b00, div_reg};
        ge    = !diff[DIV_W+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= (start && ovf_c) || (run_reg && (cnt_reg == CNT_LAST));
            if (start) begin
                run_reg <= !ovf_c;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            ovf_reg <= ovf_c;
            rem_reg <= DIV_W'(dividend[ACC_W-1:DIST_W]);
            low_reg <= dividend[DIST_W-1:0];
            div_reg <= divisor;
            q_reg   <= '0;
        end else if (run_reg) begin
            rem_reg <= ge ? diff[DIV_W-1:0] : cand[DIV_W-1:0];
            low_reg <= {low_reg[DIST_W-2:0], 1'b0};
            q_reg   <= {q_reg[DIST_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign ovf  = ovf_reg;
    assign quot = q_reg;

endmodule

// ===== src/quadric_taubin_distance_max.sv =====
// Per point: 27 serial multiplies, normalising shifts of the gradient, a square root and a divide.
// One point at a time: a new point is accepted only in the idle state.
// The output register lets the next point start while a result waits to be taken.
// Reset (aresetn low, synchronous) clears coefficients, running maximum and control.
`include "quadric_taubin_distance_max_macros.svh"
module quadric_taubin_distance_max import qtd_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,   // x_coord, y_coord, z_coord
    input  logic                 s_tlast,   // last_point
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata,   // distance, max_distance
    output logic [0:0]           m_tuser,   // saturated
    output logic                 m_tlast,   // set_done
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL  = 7'b0000010,
        ST_ABS  = 7'b0000100,
        ST_NORM = 7'b0001000,
        ST_SQRT = 7'b0010000,
        ST_DIV  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t                    state_reg;
    logic                      wait_reg;
    logic [STEP_W-1:0]         step_reg;
    logic [CFG_W-1:0]          coef_reg [NUM_PAIR];
    logic signed [COEF_W-1:0]  coef_w [NUM_COEF];
    logic signed [COORD_W-1:0] x_reg, y_reg, z_reg;
    logic                      last_reg;
    logic signed [COEF_W-1:0]  mono_reg [NUM_MONO];
    logic signed [ACC_W-1:0]   f_reg;
    logic signed [ACC_W-1:0]   g_reg [3];
    logic [MAG_W-1:0]          mag_reg [3];
    logic [FM_W-1:0]           fm_reg;
    logic [SHIFT_W-1:0]        shift_reg;
    logic [ACC_W-1:0]          sum_reg;
    logic [DIST_W-1:0]         dist_reg, run_max_reg;
    logic                      sat_reg;
    logic                      m_valid_reg, m_sat_reg, m_last_reg;
    logic [DIST_W-1:0]         m_dist_reg, m_max_reg;

    step_t                     op;
    logic signed [COORD_W-1:0] coord_a, coord_b;
    logic signed [COEF_W-1:0]  t_sel, op_a, op_b;
    logic signed [ACC_W-1:0]   g_sh [3];
    logic signed [ACC_W-1:0]   g_abs [3];
    logic signed [ACC_W-1:0]   f_abs;
    logic                      too_big, accept, out_load;
    logic [DIST_W-1:0]         new_max;
    logic                      mul_start, mul_busy, mul_done;
    logic signed [PROD_W-1:0]  mul_prod;
    logic                      sqrt_start, sqrt_done;
    logic [ROOT_W-1:0]         root;
    logic                      div_start, div_done, div_ovf;
    logic [DIST_W-1:0]         quot;
    logic [DIV_W-1:0]          divisor;

    for (genvar r = 0; r < NUM_PAIR; r++) begin : g_coef
        assign coef_w[2*r]   = coef_reg[r][COEF_W-1:0];
        assign coef_w[2*r+1] = coef_reg[r][CFG_W-1:COEF_W];
    end

    assign op = step_op(step_reg);

    always_comb begin
        case (op.a_idx[1:0])
            2'd0:    coord_a = x_reg;
            2'd1:    coord_a = y_reg;
            default: coord_a = z_reg;
        endcase
        case (op.b_idx[1:0])
            2'd0:    coord_b = x_reg;
            2'd1:    coord_b = y_reg;
            default: coord_b = z_reg;
        endcase
        case (op.a_idx[1:0])
            2'd0:    t_sel = $signed({1'b0, mag_reg[0][T_W-1:0]});
            2'd1:    t_sel = $signed({1'b0, mag_reg[1][T_W-1:0]});
            default: t_sel = $signed({1'b0, mag_reg[2][T_W-1:0]});
        endcase
        case (op.a_sel)
            SRC_COORD: op_a = COEF_W'(coord_a);
            SRC_COEF:  op_a = coef_w[op.a_idx];
            SRC_T:     op_a = t_sel;
            default:   op_a = '0;
        endcase
        case (op.b_sel)
            SRC_COORD: op_b = COEF_W'(coord_b);
            SRC_MONO:  op_b = mono_reg[op.b_idx[2:0]];
            SRC_T:     op_b = t_sel;
            default:   op_b = '0;
        endcase
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            g_sh[i]  = g_reg[i] >>> 12;
            g_abs[i] = g_sh[i][ACC_W-1] ? -g_sh[i] : g_sh[i];
        end
        f_abs   = f_reg[ACC_W-1] ? -f_reg : f_reg;
        too_big = (|mag_reg[0][MAG_W-1:T_W]) | (|mag_reg[1][MAG_W-1:T_W])
                | (|mag_reg[2][MAG_W-1:T_W]);
        divisor = DIV_W'(root) << shift_reg;
        new_max = (dist_reg > run_max_reg) ? dist_reg : run_max_reg;
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign mul_start  = (state_reg == ST_MUL) && !wait_reg;
    assign sqrt_start = (state_reg == ST_SQRT) && !wait_reg;
    assign div_start  = (state_reg == ST_DIV) && !wait_reg;
    assign out_load   = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);

    qtd_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start), .op_a(op_a), .op_b(op_b),
        .busy(mul_busy), .done(mul_done), .prod(mul_prod)
    );

    qtd_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sqrt_start), .radicand(sum_reg),
        .done(sqrt_done), .root(root)
    );

    qtd_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend({fm_reg, 16'h0000}),
        .divisor(divisor), .done(div_done), .ovf(div_ovf), .quot(quot)
    );

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wait_reg    <= 1'b0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
            run_max_reg <= '0;
            for (int r = 0; r < NUM_PAIR; r++) coef_reg[r] <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_PAIR_A: coef_reg[0] <= cfg_wdata;
                    REG_PAIR_B: coef_reg[1] <= cfg_wdata;
                    REG_PAIR_C: coef_reg[2] <= cfg_wdata;
                    REG_PAIR_D: coef_reg[3] <= cfg_wdata;
                    REG_PAIR_E: coef_reg[4] <= cfg_wdata;
                    default: ;
                endcase
            end
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
            if (mul_start || sqrt_start || div_start) wait_reg <= 1'b1;
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_MUL;
                        step_reg  <= '0;
                        wait_reg  <= 1'b0;
                    end
                end
                ST_MUL: begin
                    if (mul_done) begin
                        wait_reg <= 1'b0;
                        step_reg <= step_reg + 1'b1;
                        if (step_reg == STEP_LAST_G) state_reg <= ST_ABS;
                        else if (step_reg == STEP_LAST) state_reg <= ST_SQRT;
                    end
                end
                ST_ABS:  state_reg <= ST_NORM;
                ST_NORM: if (!too_big) state_reg <= ST_MUL;
                ST_SQRT: begin
                    if (sqrt_done) begin
                        wait_reg  <= 1'b0;
                        state_reg <= (root == '0) ? ST_OUT : ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        wait_reg  <= 1'b0;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        state_reg   <= ST_IDLE;
                        run_max_reg <= last_reg ? '0 : new_max;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg    <= s_tdata[15:0];
            y_reg    <= s_tdata[31:16];
            z_reg    <= s_tdata[47:32];
            last_reg <= s_tlast;
            f_reg    <= ACC_W'(coef_w[0]);
            for (int i = 0; i < 3; i++) g_reg[i] <= ACC_W'(coef_w[i+1]) <<< 12;
        end
        if ((state_reg == ST_MUL) && mul_done) begin
            case (op.dst)
                DST_MONO: mono_reg[op.d_idx] <= mul_prod[COEF_W-1:0];
                DST_F12:  f_reg <= f_reg + (mul_prod >>> 12);
                DST_F24:  f_reg <= f_reg + (mul_prod >>> 24);
                DST_G:    g_reg[op.d_idx[1:0]] <= g_reg[op.d_idx[1:0]]
                                                + (op.dbl ? (mul_prod <<< 1) : mul_prod);
                DST_SUM:  sum_reg <= sum_reg + $unsigned(mul_prod);
                default: ;
            endcase
        end
        if (state_reg == ST_ABS) begin
            for (int i = 0; i < 3; i++) mag_reg[i] <= g_abs[i][MAG_W-1:0];
            fm_reg    <= f_abs[FM_W-1:0];
            shift_reg <= '0;
            sum_reg   <= '0;
        end
        // scale the gradient down until every magnitude fits 31 bits
        if ((state_reg == ST_NORM) && too_big) begin
            for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 1;
            shift_reg <= shift_reg + 1'b1;
        end
        if ((state_reg == ST_SQRT) && sqrt_done && (root == '0)) begin
            dist_reg <= DIST_FULL;
            sat_reg  <= 1'b1;
        end
        if ((state_reg == ST_DIV) && div_done) begin
            dist_reg <= div_ovf ? DIST_FULL : quot;
            sat_reg  <= div_ovf;
        end
        if (out_load) begin
            m_dist_reg <= dist_reg;
            m_max_reg  <= new_max;
            m_sat_reg  <= sat_reg;
            m_last_reg <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_max_reg, m_dist_reg};
    assign m_tuser  = m_sat_reg;
    assign m_tlast  = m_last_reg;

    `QTD_ASSERT_IMP(a_sat_full, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[23:0] == DIST_FULL)
    `QTD_ASSERT_IMP(a_max_ge, aclk, aresetn, m_tvalid, m_tdata[47:24] >= m_tdata[23:0])
    `QTD_ASSERT_IMP(a_mul_free, aclk, aresetn, mul_start, !mul_busy)
    `QTD_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule
